### hw/rtl/mtq_pkg.sv
package mtq_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_CHECK,
      S_SCAN,
      S_SCAN_TAIL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic reject;
      logic pop_last;
      logic pop_start;
      logic scan_start;
      logic scan_issue;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic single;
      logic gone_is_max;
      logic scan_last;
   } status_type;

endpackage

### hw/rtl/mtq_ram.sv
module mtq_ram #(
   parameter int WIDTH = mtq_pkg::DATA_W,
   parameter int DEPTH = mtq_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mtq_datapath.sv
module mtq_datapath #(
   parameter int DEPTH = mtq_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [mtq_pkg::DATA_W-1:0]  req_value,
   input  mtq_pkg::cmd_type                   cmd,
   output mtq_pkg::status_type                status,
   output logic                               rsp_accepted,
   output logic [CNT_W-1:0]                   rsp_count,
   output logic                               rsp_has_max,
   output logic signed [mtq_pkg::DATA_W-1:0]  rsp_max_value
);
   import mtq_pkg::*;

   localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [IDX_W-1:0]         front_ff, front_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] max_ff, max_in;
   logic                     ok_ff, ok_in;
   logic [IDX_W-1:0]         scan_k_ff, scan_k_in;
   logic                     scan_valid_ff, scan_valid_in;
   logic                     scan_first_ff, scan_first_in;

   logic                     rsp_accepted_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic                     rsp_has_max_ff;
   logic signed [DATA_W-1:0] rsp_max_value_ff;

   logic [IDX_W-1:0]         back_off;
   logic [IDX_W-1:0]         push_front;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rd_en;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_value;

   assign back_off   = IDX_W'(count_ff - CNT_W'(1));
   assign push_front = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
   assign rd_en      = cmd.pop_start | cmd.scan_issue;
   assign rd_addr    = cmd.pop_start ? ring_add(front_ff, back_off)
                                     : ring_add(front_ff, scan_k_ff);
   assign rd_value   = rd_data;

   mtq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (push_front),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.empty       = (count_ff == '0);
      status.full        = (count_ff == DEPTH_CNT);
      status.single      = (count_ff == CNT_W'(1));
      status.gone_is_max = (rd_value == max_ff);
      status.scan_last   = (CNT_W'(scan_k_ff) == count_ff - CNT_W'(1));
   end

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      max_in        = max_ff;
      ok_in         = ok_ff;
      scan_k_in     = scan_k_ff;
      scan_valid_in = cmd.scan_issue;
      scan_first_in = cmd.scan_issue && (scan_k_ff == '0);

      if (cmd.push) begin
         front_in = push_front;
         count_in = count_ff + CNT_W'(1);
         ok_in    = 1'b1;
         if (count_ff == '0 || req_value > max_ff) begin
            max_in = req_value;
         end
      end
      if (cmd.reject) begin
         ok_in = 1'b0;
      end
      if (cmd.pop_last) begin
         front_in = '0;
         count_in = '0;
         max_in   = '0;
         ok_in    = 1'b1;
      end
      if (cmd.pop_start) begin
         count_in = count_ff - CNT_W'(1);
         ok_in    = 1'b1;
      end
      if (cmd.scan_start) begin
         scan_k_in = '0;
      end
      if (cmd.scan_issue) begin
         scan_k_in = scan_k_ff + IDX_W'(1);
      end
      if (scan_valid_ff) begin
         if (scan_first_ff || rd_value > max_ff) begin
            max_in = rd_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         max_ff        <= '0;
         ok_ff         <= 1'b0;
         scan_valid_ff <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         max_ff        <= max_in;
         ok_ff         <= ok_in;
         scan_valid_ff <= scan_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_k_ff     <= scan_k_in;
      scan_first_ff <= scan_first_in;
      if (cmd.rsp_load) begin
         rsp_accepted_ff  <= ok_ff;
         rsp_count_ff     <= count_ff;
         rsp_has_max_ff   <= (count_ff != '0);
         rsp_max_value_ff <= max_ff;
      end
   end

   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_has_max   = rsp_has_max_ff;
   assign rsp_max_value = rsp_max_value_ff;

endmodule

### hw/rtl/mtq_ctrl.sv
module mtq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mtq_pkg::cmd_type    cmd,
   input  mtq_pkg::status_type status
);
   import mtq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_mode == MODE_PUSH) begin
                  if (status.full) begin
                     cmd.reject = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                  end
                  state_in = S_DONE;
               end else begin
                  priority if (status.empty) begin
                     cmd.reject = 1'b1;
                     state_in   = S_DONE;
                  end else if (status.single) begin
                     cmd.pop_last = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     cmd.pop_start = 1'b1;
                     state_in      = S_POP_CHECK;
                  end
               end
            end
         end
         S_POP_CHECK: begin
            if (status.gone_is_max) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = S_SCAN_TAIL;
            end
         end
         S_SCAN_TAIL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/max_tracking_queue.sv
// channel   direction  beat fields
// req_      in         mode (0 push at front, 1 pop from back), value
// rsp_      out        accepted, count, has_max, max_value
//
// Push and rejected items go straight to the response state; a pop from a queue of
// two or more entries first checks whether it removed the maximum. If so, it rescans
// the remaining N entries through the single read port of the entry RAM, one per cycle.
// Reset clears count, front index and maximum; the entry RAM is not cleared.
// A new beat is taken while the previous result still waits on rsp_stall;
// its result then waits for the output register.
module max_tracking_queue #(
   parameter int DEPTH = mtq_pkg::DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic signed [mtq_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic [CNT_W-1:0]                   rsp_count,
   output logic                               rsp_has_max,
   output logic signed [mtq_pkg::DATA_W-1:0]  rsp_max_value
);
   import mtq_pkg::*;

   cmd_type    cmd;
   status_type status;

   mtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mtq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_accepted  (rsp_accepted),
      .rsp_count     (rsp_count),
      .rsp_has_max   (rsp_has_max),
      .rsp_max_value (rsp_max_value)
   );

endmodule

### hw/rtl/mtq_checker.sv
module mtq_checker #(
   parameter int DEPTH = mtq_pkg::DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_accepted,
   input logic [CNT_W-1:0]                   rsp_count,
   input logic                               rsp_has_max,
   input logic signed [mtq_pkg::DATA_W-1:0]  rsp_max_value
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   a_has_max_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_max == (rsp_count != '0)))
      else $error("has_max disagrees with count");

   a_empty_max_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_max) |-> (rsp_max_value == '0))
      else $error("empty queue reports nonzero maximum");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= DEPTH_CNT))
      else $error("count beyond depth");

   a_reject_only_at_limits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_count == '0 || rsp_count == DEPTH_CNT))
      else $error("rejection while neither empty nor full");

   a_stalled_beat_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_count)
                                    && $stable(rsp_max_value)))
      else $error("stalled result changed");

endmodule

bind max_tracking_queue mtq_checker #(
   .DEPTH (DEPTH)
) u_mtq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_accepted  (rsp_accepted),
   .rsp_count     (rsp_count),
   .rsp_has_max   (rsp_has_max),
   .rsp_max_value (rsp_max_value)
);
